// File: design/spq_pkg.sv
// spq_pkg: shared types and constants for the sorted priority queue
// no dependencies
`default_nettype none
package spq_pkg;

  localparam int DEPTH = 8;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                    opcode;
    logic signed [VAL_W-1:0] value;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [3:0]              entry_count;
    logic signed [VAL_W-1:0] top_value;
    logic                    top_valid;
  } spq_out_t;

  // signals a cell hands to its right-hand neighbor
  typedef struct packed {
    logic mark;   // insert point is at or left of this cell
    logic found;  // delete match is at or left of this cell
  } spq_link_t;

endpackage
`default_nettype wire

// File: design/spq_cell.sv
// spq_cell: one slot of the sorted chain, compares against the incoming value and shifts when wr_en is high
// depends on spq_pkg
`default_nettype none
module spq_cell (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic                           opcode,
  input  wire logic signed [spq_pkg::VAL_W-1:0] value,
  input  wire logic                           occ,
  input  wire logic signed [spq_pkg::VAL_W-1:0] left_ent,
  input  wire logic signed [spq_pkg::VAL_W-1:0] right_ent,
  input  wire spq_pkg::spq_link_t             left_link,
  output spq_pkg::spq_link_t                  link,
  output logic signed [spq_pkg::VAL_W-1:0]    ent,
  output logic signed [spq_pkg::VAL_W-1:0]    ent_nxt
);
  import spq_pkg::*;

  logic signed [VAL_W-1:0] ent_r;

  assign link.mark  = !occ || (value >= ent_r);
  assign link.found = left_link.found || (occ && (value == ent_r));

  always_comb begin
    ent_nxt = ent_r;
    if (opcode == OP_INSERT) begin
      if (left_link.mark) begin
        ent_nxt = left_ent;
      end else if (link.mark) begin
        ent_nxt = value;
      end
    end else begin
      if (link.found) begin
        ent_nxt = right_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

// File: design/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue kept in descending order
// depends on spq_pkg and spq_cell
`default_nettype none
// channel   direction  word type   handshake
// in_       input      spq_in_t    in_valid / in_stall
// out_      output     spq_out_t   out_valid / out_stall
//
// one operation per cycle unless in_stall is high: every cell compares
// against the incoming value and shifts left or right in the same cycle,
// the count register settles on that same edge and the result word lands in the output register.
// reset clears the count and the output valid; slot contents are not reset.
// a word waiting at the output stalls the input only while out_stall is high.
module sorted_priority_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire spq_pkg::spq_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output spq_pkg::spq_out_t      out_data
);
  import spq_pkg::*;

  logic                    accept;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    full, empty;
  logic                    wr_en;
  logic [1:0]              status;
  logic                    out_valid_r;
  spq_out_t                out_r;

  spq_link_t               links [DEPTH];
  logic signed [VAL_W-1:0] ents  [DEPTH];
  logic signed [VAL_W-1:0] ent_nxts [DEPTH];

  // output register frees up whenever the downstream side takes its word
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // chain of slots: slot 0 holds the largest entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_link_t               left_link;
    logic signed [VAL_W-1:0] left_ent, right_ent;

    if (i == 0) begin : g_first
      assign left_link = '0;
      assign left_ent  = '0;
    end else begin : g_mid
      assign left_link = links[i-1];
      assign left_ent  = ents[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .wr_en     (wr_en),
      .opcode    (in_data.opcode),
      .value     (in_data.value),
      .occ       (CNT_W'(i) < count_r),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .left_link (left_link),
      .link      (links[i]),
      .ent       (ents[i]),
      .ent_nxt   (ent_nxts[i])
    );
  end

  // status and count update, the found flag comes out of the last slot
  always_comb begin
    status    = ST_DONE;
    count_nxt = count_r;
    wr_en     = 1'b0;
    if (in_data.opcode == OP_INSERT) begin
      if (full) begin
        status = ST_OVERFLOW;
      end else begin
        wr_en     = accept;
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status = ST_EMPTY;
      end else if (!links[DEPTH-1].found) begin
        status = ST_NOT_FOUND;
      end else begin
        wr_en     = accept;
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word, top entry taken from slot 0's next value when the slots
  // are written, otherwise from slot 0 as it stands
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r.status      <= status;
      out_r.entry_count <= 4'(count_nxt);
      out_r.top_valid   <= (count_nxt != '0);
      out_r.top_value   <= (count_nxt != '0) ? (wr_en ? ent_nxts[0] : ents[0]) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: verif/spq_checker.sv
// spq_checker: watches both channels of the sorted priority queue, predicts each result word
// and compares it field by field; depends on spq_pkg
module spq_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire spq_pkg::spq_in_t  in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire spq_pkg::spq_out_t out_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  // predicted contents, slot 0 largest
  logic signed [VAL_W-1:0] held_vals [DEPTH];
  int                      held_num;
  spq_out_t                expected_words [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    held_num   = 0;
  end

  // apply one operation to the predicted store and build its result word
  function automatic spq_out_t apply_op(spq_in_t w);
    spq_out_t r;
    int       pos;
    r = '0;
    if (w.opcode == OP_INSERT) begin
      if (held_num >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        // new value goes ahead of the first entry not larger than it
        pos = held_num;
        for (int k = 0; k < held_num; k++) begin
          if (pos == held_num && $signed(w.value) >= $signed(held_vals[k])) pos = k;
        end
        for (int k = held_num; k > pos; k--) held_vals[k] = held_vals[k-1];
        held_vals[pos] = w.value;
        held_num++;
        r.status = ST_DONE;
      end
    end else begin
      if (held_num == 0) begin
        r.status = ST_EMPTY;
      end else begin
        pos = -1;
        for (int k = 0; k < held_num; k++) begin
          if (pos < 0 && held_vals[k] == w.value) pos = k;
        end
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int k = pos; k < held_num - 1; k++) held_vals[k] = held_vals[k+1];
          held_num--;
          r.status = ST_DONE;
        end
      end
    end
    r.entry_count = 4'(held_num);
    r.top_valid   = (held_num > 0);
    r.top_value   = (held_num > 0) ? held_vals[0] : '0;
    return r;
  endfunction

  task automatic flag_field(input string field, input logic signed [VAL_W:0] want_v,
                            input logic signed [VAL_W:0] got_v);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    spq_out_t want;
    if (!rst_n) begin
      held_num = 0;
      expected_words.delete();
    end else begin
      // result check first, it belongs to a word accepted on an earlier edge
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 40)
            $display("%0t: unexpected result word, expected none, got %p", $time, out_data);
        end else begin
          want = expected_words.pop_front();
          if (out_data.status !== want.status)
            flag_field("status", (VAL_W+1)'(want.status), (VAL_W+1)'(out_data.status));
          if (out_data.entry_count !== want.entry_count)
            flag_field("entry_count", (VAL_W+1)'(want.entry_count),
                       (VAL_W+1)'(out_data.entry_count));
          if (out_data.top_value !== want.top_value)
            flag_field("top_value", (VAL_W+1)'(want.top_value),
                       (VAL_W+1)'(out_data.top_value));
          if (out_data.top_valid !== want.top_valid)
            flag_field("top_valid", (VAL_W+1)'(want.top_valid),
                       (VAL_W+1)'(out_data.top_valid));
        end
      end
      if (in_valid && !in_stall) expected_words.push_back(apply_op(in_data));
    end
    pending = expected_words.size();
  end

endmodule

// File: verif/tb_top.sv
// tb_top: stimulus and verdict for sorted_priority_queue, with spq_checker beside the block
// depends on spq_pkg, spq_checker and the design
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam logic signed [VAL_W-1:0] MAX_VAL = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] MIN_VAL = 32'sh80000000;
  localparam int POOL_N = 10;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  spq_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  spq_out_t out_data;
  int       fail_count;
  int       pending;

  // sender burst bookkeeping
  int burst_left;
  // values that inserts and deletes draw from, so deletes often hit
  logic signed [VAL_W-1:0] pool [POOL_N];

  sorted_priority_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  spq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // offer one word at the falling edge and hold it until accepted,
  // then either keep the burst going or drop valid for a random gap
  task automatic offer(input logic op, input logic signed [VAL_W-1:0] v);
    spq_in_t w;
    spq_in_t junk;
    int      gap;
    w.opcode = op;
    w.value  = v;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      // payload is free to wander while valid is low
      junk.opcode = $urandom_range(0, 1);
      junk.value  = $urandom;
      in_valid <= 1'b0;
      in_data  <= junk;
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(8, 30);
      else gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // sender pause until every predicted word has come back
  task automatic drain_all();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: stall pattern of its own, in segments of random length;
  // every seventh segment is a long hold so a word waits at the output and the block stalls its input
  initial begin : receiver
    int seg_num;
    int seg_len;
    int stall_pct;
    out_stall = 1'b0;
    seg_num   = 0;
    wait (rst_n === 1'b1);
    forever begin
      seg_num++;
      if (seg_num % 7 == 3) begin
        seg_len = $urandom_range(40, 64);
        repeat (seg_len) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;    // free running
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = -1;   // alternates between stalled and free
        endcase
        seg_len = $urandom_range(8, 60);
        for (int c = 0; c < seg_len; c++) begin
          @(negedge clk);
          if (stall_pct < 0) out_stall <= c[0];
          else out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
      end
    end
  end

  initial begin : stimulus
    int                      remaining;
    int                      phase_len;
    int                      phase_num;
    int                      insert_pct;
    logic                    op;
    logic signed [VAL_W-1:0] v;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    burst_left = $urandom_range(1, 40);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty delete, extremes, equal values, miss, head and tail removal
    offer(OP_DELETE, 0);          // empty queue
    offer(OP_INSERT, 0);
    offer(OP_INSERT, MAX_VAL);
    offer(OP_INSERT, MIN_VAL);
    offer(OP_INSERT, -1);
    offer(OP_INSERT, 0);          // equal to a held entry, goes ahead of it
    offer(OP_DELETE, 5);          // no match
    offer(OP_DELETE, MIN_VAL);    // last slot
    offer(OP_DELETE, MAX_VAL);    // top slot
    offer(OP_INSERT, 7);
    offer(OP_INSERT, 7);
    offer(OP_INSERT, -7);
    offer(OP_INSERT, 100);
    offer(OP_INSERT, -100);       // store now full
    offer(OP_INSERT, 9);          // overflow
    offer(OP_INSERT, MIN_VAL);    // overflow, smallest value
    offer(OP_DELETE, 0);          // one of two equal entries in the middle
    offer(OP_DELETE, 100);
    offer(OP_DELETE, -7);
    offer(OP_DELETE, -100);
    offer(OP_DELETE, 7);
    offer(OP_DELETE, 7);
    offer(OP_DELETE, -1);
    offer(OP_DELETE, 0);          // back to empty
    offer(OP_DELETE, -1);         // empty again
    drain_all();

    // random phases: each phase leans toward filling or emptying the store,
    // with a fresh value pool so equal values and delete hits are common
    remaining = 1880;
    phase_num = 0;
    while (remaining > 0) begin
      phase_len = $urandom_range(60, 200);
      if (phase_len > remaining) phase_len = remaining;
      case ($urandom_range(0, 2))
        0:       insert_pct = 30;
        1:       insert_pct = 50;
        default: insert_pct = 75;
      endcase
      foreach (pool[i]) begin
        case ($urandom_range(0, 3))
          0:       pool[i] = $urandom_range(0, 6) - 3;
          1:       pool[i] = $urandom;
          2:       pool[i] = $urandom_range(0, 1) ? MAX_VAL : MIN_VAL;
          default: pool[i] = $urandom_range(0, 200) - 100;
        endcase
      end
      repeat (phase_len) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
        // a few fully random values keep every value bit moving and give misses
        if ($urandom_range(0, 7) == 0) v = $urandom;
        else v = pool[$urandom_range(0, POOL_N - 1)];
        offer(op, v);
      end
      remaining -= phase_len;
      phase_num++;
      if (phase_num % 3 == 0) drain_all();
    end

    // wait out the last results, then idle a little longer for anything stray
    drain_all();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
